/* sv/ktrt_pkg.sv */
// ----------------------------------------------------------------------------
// ktrt_pkg
// Shared types and constants for the keyed tile record table: the stored
// record layout, the search accumulator passed along the cell row, the
// write controls broadcast to the cells, operation codes and FSM states.
// ----------------------------------------------------------------------------
package ktrt_pkg;

    // default capacity of the table
    localparam int KTRT_TABLE_ENTRIES = 256;

    // cells chained without a register between them
    localparam int KTRT_SEG_CELLS = 8;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } ktrt_op_t;

    // top level control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESOLVE
    } ktrt_state_t;

    // one stored tile record
    typedef struct packed {
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic signed [15:0] draw_dx;
        logic signed [15:0] draw_dy;
        logic        [7:0]  atlas_index;
    } ktrt_rec_t;

    // match flag and matched record handed from cell to cell
    typedef struct packed {
        logic      hit;
        ktrt_rec_t rec;
    } ktrt_acc_t;

    // write controls broadcast to every cell
    typedef struct packed {
        logic update;
        logic append;
    } ktrt_ctl_t;

endpackage

/* sv/ktrt_cell.sv */
// ----------------------------------------------------------------------------
// ktrt_cell
// One table entry: holds a key and its record, compares the key against the
// query and merges its record into the accumulator passed down the row.
// ----------------------------------------------------------------------------
module ktrt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  logic                clk,
    input  logic [15:0]         qkey,
    input  logic [CNT_W-1:0]    count,
    input  ktrt_pkg::ktrt_ctl_t ctl,
    input  ktrt_pkg::ktrt_rec_t wrec,
    input  ktrt_pkg::ktrt_acc_t acc_in,
    output ktrt_pkg::ktrt_acc_t acc_out
);
    import ktrt_pkg::*;

    logic [15:0] key_reg;
    ktrt_rec_t   rec_reg;
    logic        in_use;
    logic        match;
    logic        wr_en;

    // entry takes part only below the fill count
    assign in_use = (count > CNT_W'(INDEX));
    assign match  = in_use && (key_reg == qkey);

    // update on key match, append at the fill count
    assign wr_en = (ctl.update && match) || (ctl.append && (count == CNT_W'(INDEX)));

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg <= qkey;
            rec_reg <= wrec;
        end
    end

    // keys are unique below the fill count, so at most one cell matches
    always_comb
    begin
        acc_out.hit = acc_in.hit | match;
        acc_out.rec = acc_in.rec | (match ? rec_reg : '0);
    end

endmodule

/* sv/ktrt_segment.sv */
// ----------------------------------------------------------------------------
// ktrt_segment
// A short run of cells chained combinationally, with the accumulated search
// result registered at its end before it moves on to the next segment.
// ----------------------------------------------------------------------------
module ktrt_segment #(
    parameter int FIRST_INDEX = 0,
    parameter int NUM_CELLS   = 8,
    parameter int CNT_W       = 9
) (
    input  logic                clk,
    input  logic [15:0]         qkey,
    input  logic [CNT_W-1:0]    count,
    input  ktrt_pkg::ktrt_ctl_t ctl,
    input  ktrt_pkg::ktrt_rec_t wrec,
    input  ktrt_pkg::ktrt_acc_t acc_in,
    output ktrt_pkg::ktrt_acc_t acc_out
);
    import ktrt_pkg::*;

    ktrt_acc_t acc_link [0:NUM_CELLS];
    ktrt_acc_t acc_reg;

    assign acc_link[0] = acc_in;

    // row of cells
    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        ktrt_cell #(
            .INDEX (FIRST_INDEX + c),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk     (clk),
            .qkey    (qkey),
            .count   (count),
            .ctl     (ctl),
            .wrec    (wrec),
            .acc_in  (acc_link[c]),
            .acc_out (acc_link[c+1])
        );
    end

    // hop register toward the next segment
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_link[NUM_CELLS];
    end

    assign acc_out = acc_reg;

endmodule

/* sv/keyed_tile_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_tile_record_table
// Fixed-capacity tile record table keyed by a 16-bit tile id, built as a row
// of entry cells searched in parallel.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Insert and lookup search every entry
// at once; the match result travels down the cell row through one register
// per group of KTRT_SEG_CELLS cells, so their result is loaded once it has
// passed every register hop in the row, and the next transaction is taken
// after the result is loaded. Clear, a rejected insert on a full table and
// the unused code skip the search and load their result directly. A
// finished result sits in an output register, and the next transaction is
// accepted while it waits; the block stalls only when a second result is
// ready before the first is taken. Keys are unique among held entries, key 0
// can be stored but is never found, and a full table rejects every insert,
// updates included.
// ----------------------------------------------------------------------------
module keyed_tile_record_table #(
    parameter int TABLE_ENTRIES = ktrt_pkg::KTRT_TABLE_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [15:0]        tile_id,
    input  logic signed [15:0] src_x,
    input  logic signed [15:0] src_y,
    input  logic signed [15:0] width,
    input  logic signed [15:0] height,
    input  logic signed [15:0] draw_dx,
    input  logic signed [15:0] draw_dy,
    input  logic [7:0]         atlas_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               insert_ok,
    output logic               found,
    output logic signed [15:0] hit_src_x,
    output logic signed [15:0] hit_src_y,
    output logic signed [15:0] hit_width,
    output logic signed [15:0] hit_height,
    output logic signed [15:0] hit_draw_dx,
    output logic signed [15:0] hit_draw_dy,
    output logic [7:0]         hit_atlas_index,
    output logic [8:0]         fill_count
);
    import ktrt_pkg::*;

    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int SEG_CELLS = KTRT_SEG_CELLS;
    localparam int NSEG      = (TABLE_ENTRIES + SEG_CELLS - 1) / SEG_CELLS;
    localparam int HOP_W     = (NSEG > 1) ? $clog2(NSEG) : 1;

    ktrt_state_t      state_reg, state_next;
    logic [HOP_W-1:0] hop_reg, hop_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;

    logic [1:0]       op_reg;
    logic [15:0]      key_reg;
    ktrt_rec_t        wrec_reg;

    logic             insert_ok_reg;
    logic             found_reg;
    ktrt_rec_t        hit_rec_reg;
    logic [CNT_W-1:0] fill_reg;

    logic             accept;
    logic             in_full;
    logic             full;
    logic             out_free;
    logic             out_load;
    logic             hit;
    logic             res_insert_ok;
    logic             res_found;
    ktrt_rec_t        res_rec;
    ktrt_ctl_t        ctl;
    ktrt_acc_t        acc_chain [0:NSEG];

    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign in_full  = full;
    assign out_free = !out_valid_reg || out_ready;
    assign hit      = acc_chain[NSEG].hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op == OP_LOOKUP) || ((op == OP_INSERT) && !in_full))
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_RESOLVE;
                end
            end
            ST_SEARCH:
            begin
                if (hop_reg == HOP_W'(NSEG - 1))
                    state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = 1'b0;
        out_load   = 1'b0;
        hop_next   = '0;
        ctl.update = 1'b0;
        ctl.append = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SEARCH:
            begin
                hop_next = hop_reg + HOP_W'(1);
            end
            ST_RESOLVE:
            begin
                out_load   = out_free;
                ctl.update = out_free && res_insert_ok && hit;
                ctl.append = out_free && res_insert_ok && !hit;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // result of the held transaction
    always_comb
    begin
        res_insert_ok = (op_reg == OP_INSERT) && !full;
        res_found     = (op_reg == OP_LOOKUP) && (key_reg != 16'd0) && hit;
        res_rec       = res_found ? acc_chain[NSEG].rec : '0;
        case (op_reg)
            OP_INSERT:
            begin
                count_next = (res_insert_ok && !hit) ? count_reg + CNT_W'(1) : count_reg;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hop_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hop_reg   <= hop_next;
            if (out_load)
                count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg               <= op;
            key_reg              <= tile_id;
            wrec_reg.src_x       <= src_x;
            wrec_reg.src_y       <= src_y;
            wrec_reg.width       <= width;
            wrec_reg.height      <= height;
            wrec_reg.draw_dx     <= draw_dx;
            wrec_reg.draw_dy     <= draw_dy;
            wrec_reg.atlas_index <= atlas_index;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            insert_ok_reg <= res_insert_ok;
            found_reg     <= res_found;
            hit_rec_reg   <= res_rec;
            fill_reg      <= count_next;
        end
    end

    // cell row, one register hop per segment
    assign acc_chain[0] = '0;

    for (genvar s = 0; s < NSEG; s++)
    begin : g_seg
        localparam int FIRST = s * SEG_CELLS;
        localparam int LEFT  = TABLE_ENTRIES - FIRST;
        localparam int CELLS = (LEFT < SEG_CELLS) ? LEFT : SEG_CELLS;

        ktrt_segment #(
            .FIRST_INDEX (FIRST),
            .NUM_CELLS   (CELLS),
            .CNT_W       (CNT_W)
        ) u_seg (
            .clk     (clk),
            .qkey    (key_reg),
            .count   (count_reg),
            .ctl     (ctl),
            .wrec    (wrec_reg),
            .acc_in  (acc_chain[s]),
            .acc_out (acc_chain[s+1])
        );
    end

    // port drive
    assign out_valid       = out_valid_reg;
    assign insert_ok       = insert_ok_reg;
    assign found           = found_reg;
    assign hit_src_x       = hit_rec_reg.src_x;
    assign hit_src_y       = hit_rec_reg.src_y;
    assign hit_width       = hit_rec_reg.width;
    assign hit_height      = hit_rec_reg.height;
    assign hit_draw_dx     = hit_rec_reg.draw_dx;
    assign hit_draw_dy     = hit_rec_reg.draw_dy;
    assign hit_atlas_index = hit_rec_reg.atlas_index;
    assign fill_count      = 9'(fill_reg);

    // fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count above capacity");

    // fill count moves only when a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(count_reg))
        else $error("fill count changed outside result load");

    // an accepted transaction leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("stayed idle after accepting a transaction");

    // an insert result and a lookup hit never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(insert_ok_reg && found_reg))
        else $error("insert and lookup flags both set");

    // update and append are never driven at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.update && ctl.append))
        else $error("update and append both active");

endmodule
